@@ hdl/sbmm_pkg.sv @@
// Shared types, codes and word layouts for the slot bank memory mapper.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package sbmm_pkg;

  // Default width of the in-slot offset (16 KB slots)
  localparam int unsigned SLOT_OFFSET_BITS_DEF = 14;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned BANK_W  = 8;
  localparam int unsigned BANK0_W = 6;
  localparam int unsigned SRCSEL_W = 6;
  localparam int unsigned PHYS_W  = 22;
  localparam int unsigned TGT_W   = 3;
  localparam int unsigned NUM_UPPER = 3;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // Result word layout, lowest bit first
  localparam int unsigned OUT_TGT_LSB  = 0;
  localparam int unsigned OUT_PHYS_LSB = OUT_TGT_LSB + TGT_W;
  localparam int unsigned OUT_RD_BIT   = OUT_PHYS_LSB + PHYS_W;
  localparam int unsigned OUT_WR_BIT   = OUT_RD_BIT + 1;
  localparam int unsigned OUT_OB_BIT   = OUT_WR_BIT + 1;
  localparam int unsigned OUT_LED_LSB  = OUT_OB_BIT + 1;
  localparam int unsigned OUT_USED_W   = OUT_LED_LSB + DATA_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_PAGES = 1'b0;
  localparam logic [DATA_W-1:0]    ROM_PAGES_RST = 8'd16;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_IOWR  = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_INT  = 2'd0,
    SRC_AV   = 2'd1,
    SRC_EXP0 = 2'd2,
    SRC_EXP1 = 2'd3
  } src_e;

  typedef enum logic [TGT_W-1:0] {
    TGT_NONE = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_AV   = 3'd3,
    TGT_EXP0 = 3'd4,
    TGT_EXP1 = 3'd5
  } target_e;

  // I/O port numbers (low address byte)
  localparam logic [7:0] PORT_BANK0   = 8'h00;
  localparam logic [7:0] PORT_BANK1   = 8'h01;
  localparam logic [7:0] PORT_BANK2   = 8'h02;
  localparam logic [7:0] PORT_BANK3   = 8'h03;
  localparam logic [7:0] PORT_SRCSEL  = 8'h04;
  localparam logic [7:0] PORT_LED     = 8'h05;
  localparam logic [7:0] PORT_LED_ALT = 8'h0D;

  typedef struct packed {
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] address;
    op_e               op;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]                   rom_pages;
    logic [SRCSEL_W-1:0]                 src_sel;
    logic [NUM_UPPER-1:0][BANK_W-1:0]    upper_bank;
    logic [BANK0_W-1:0]                  slot0_bank;
  } map_state_t;

  typedef struct packed {
    logic          bus_float;
    logic          write_en;
    logic          read_en;
    logic [PHYS_W-1:0] phys_addr;
    target_e       target;
  } map_result_t;

endpackage

`default_nettype wire

@@ hdl/sbmm_xlate.sv @@
// Address translation for one bus cycle: slot, source and bank lookup.
// Pure combinational; uses sbmm_pkg types.
`default_nettype none

module sbmm_xlate #(
  parameter int unsigned SlotOffsetBits = sbmm_pkg::SLOT_OFFSET_BITS_DEF
) (
  input  sbmm_pkg::item_t       item_i,
  input  sbmm_pkg::map_state_t  state_i,
  output sbmm_pkg::map_result_t result_o
);
  import sbmm_pkg::*;

  logic [1:0]              slot;
  logic [BANK_W-1:0]       bank;
  src_e                    src;
  logic [BANK_W-1:0]       page;
  logic [SlotOffsetBits-1:0] offset;
  logic                    is_mem;
  logic                    is_rd;

  assign slot   = item_i.address[ADDR_W-1 -: 2];
  assign offset = item_i.address[SlotOffsetBits-1:0];
  assign is_rd  = (item_i.op == OP_READ);
  assign is_mem = is_rd || (item_i.op == OP_WRITE);

  always_comb begin
    case (slot)
      2'd0: begin
        bank = {{(BANK_W-BANK0_W){1'b0}}, state_i.slot0_bank};
        src  = SRC_INT;
      end
      2'd1: begin
        bank = state_i.upper_bank[0];
        src  = src_e'(state_i.src_sel[1:0]);
      end
      2'd2: begin
        bank = state_i.upper_bank[1];
        src  = src_e'(state_i.src_sel[3:2]);
      end
      default: begin
        bank = state_i.upper_bank[2];
        src  = src_e'(state_i.src_sel[5:4]);
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    page     = bank;
    if (is_mem) begin
      case (src)
        SRC_INT: begin
          if (bank < state_i.rom_pages) begin
            result_o.target  = TGT_ROM;
            result_o.read_en = is_rd;
          end else begin
            // RAM pages start right after the last ROM page
            page              = bank - state_i.rom_pages;
            result_o.target   = TGT_RAM;
            result_o.read_en  = is_rd;
            result_o.write_en = !is_rd;
          end
        end
        SRC_AV: begin
          result_o.target    = TGT_AV;
          result_o.bus_float = is_rd;
        end
        SRC_EXP0: begin
          result_o.target    = TGT_EXP0;
          result_o.bus_float = is_rd;
        end
        default: begin
          result_o.target    = TGT_EXP1;
          result_o.bus_float = is_rd;
        end
      endcase
      result_o.phys_addr = PHYS_W'({{(PHYS_W-BANK_W){1'b0}}, page} << SlotOffsetBits)
                         | PHYS_W'(offset);
    end
  end

endmodule

`default_nettype wire

@@ hdl/slot_bank_memory_mapper_core.sv @@
// Slot bank memory mapper: input word register, translation, result register.
// A word accepted into the input word register moves on into the result
// register (two register stages); one word per cycle unless output stalls.
// Bank, source-select and LED registers change as an I/O write word passes
// into the result register. Reset clears valids, slot 0 bank, source select
// and sets rom_pages to 16; upper banks and LEDs hold no reset value.
`default_nettype none

module slot_bank_memory_mapper_core #(
  parameter int unsigned SlotOffsetBits = sbmm_pkg::SLOT_OFFSET_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sbmm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [sbmm_pkg::DATA_W-1:0]         cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // op[1:0], address[17:2], write_data[25:18], zero pad
  input  wire logic [sbmm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // target[2:0], physical_address[24:3], read_enable[25], write_enable[26],
  // bus_float[27], led_state[35:28], zero pad
  output logic [sbmm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
  import sbmm_pkg::*;

  logic        in_vld_q, in_vld_d;
  item_t       in_item_q;
  logic        out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [DATA_W-1:0]                rom_pages_q;
  logic [BANK0_W-1:0]               slot0_bank_q, slot0_bank_d;
  logic [SRCSEL_W-1:0]              src_sel_q, src_sel_d;
  logic [NUM_UPPER-1:0][BANK_W-1:0] upper_bank_q, upper_bank_d;
  logic [DATA_W-1:0]                led_q, led_d;

  logic        s_accept;
  logic        advance;
  map_state_t  map_state;
  map_result_t map_res;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  assign map_state.rom_pages  = rom_pages_q;
  assign map_state.src_sel    = src_sel_q;
  assign map_state.upper_bank = upper_bank_q;
  assign map_state.slot0_bank = slot0_bank_q;

  sbmm_xlate #(
    .SlotOffsetBits(SlotOffsetBits)
  ) u_xlate (
    .item_i  (in_item_q),
    .state_i (map_state),
    .result_o(map_res)
  );

  // I/O port decode; takes effect as the word moves on
  always_comb begin
    slot0_bank_d = slot0_bank_q;
    src_sel_d    = src_sel_q;
    upper_bank_d = upper_bank_q;
    led_d        = led_q;
    if (advance && in_item_q.op == OP_IOWR) begin
      unique case (in_item_q.address[7:0]) inside
        PORT_BANK0:   slot0_bank_d    = in_item_q.write_data[BANK0_W-1:0];
        PORT_BANK1:   upper_bank_d[0] = in_item_q.write_data;
        PORT_BANK2:   upper_bank_d[1] = in_item_q.write_data;
        PORT_BANK3:   upper_bank_d[2] = in_item_q.write_data;
        PORT_SRCSEL:  src_sel_d       = in_item_q.write_data[DATA_W-1:2];
        PORT_LED, PORT_LED_ALT: led_d = in_item_q.write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      rom_pages_q  <= ROM_PAGES_RST;
      slot0_bank_q <= '0;
      src_sel_q    <= '0;
    end else begin
      in_vld_q     <= in_vld_d;
      out_vld_q    <= out_vld_d;
      slot0_bank_q <= slot0_bank_d;
      src_sel_q    <= src_sel_d;
      // floating-bus byte is supplied on the memory side; only rom_pages is kept
      if (cfg_we_i && cfg_index_i == CFG_ROM_PAGES) begin
        rom_pages_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    upper_bank_q <= upper_bank_d;
    led_q        <= led_d;
    if (s_accept) begin
      in_item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
    if (advance) begin
      out_data_q <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, led_d, map_res};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ hdl/sbmm_checker.sv @@
// Port-level checks for slot_bank_memory_mapper_core, bound to the top level.
// Uses the result word layout from sbmm_pkg.
`default_nettype none

module sbmm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [sbmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import sbmm_pkg::*;

  logic [TGT_W-1:0]  tgt;
  logic [PHYS_W-1:0] phys;
  logic              rd, wr, ob;

  assign tgt  = m_axis_tdata[OUT_TGT_LSB +: TGT_W];
  assign phys = m_axis_tdata[OUT_PHYS_LSB +: PHYS_W];
  assign rd   = m_axis_tdata[OUT_RD_BIT];
  assign wr   = m_axis_tdata[OUT_WR_BIT];
  assign ob   = m_axis_tdata[OUT_OB_BIT];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_wr_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && wr |-> tgt == TGT_RAM && !rd && !ob)
    else $error("write enable outside internal RAM");

  a_ob_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob |-> (tgt == TGT_AV || tgt == TGT_EXP0 || tgt == TGT_EXP1) && !rd)
    else $error("floating bus on internal target");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tgt == TGT_NONE |-> phys == '0 && !rd && !wr && !ob)
    else $error("idle or I/O word carries a mapping");

endmodule

bind slot_bank_memory_mapper_core sbmm_checker u_sbmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
